// ===== hdl/line_segment_intersection_assert.svh =====
// Assertion macros for the segment intersection block.
// Used by the top level; expects clk and rst in scope.
`ifndef LINE_SEGMENT_INTERSECTION_ASSERT_SVH
`define LINE_SEGMENT_INTERSECTION_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("line_segment_intersection check failed");

// Same check with a caller-supplied message string.
`define LSI_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hdl/lsi_pkg.sv =====
// Shared widths, stage records and helper functions for the segment intersection block.
// No dependencies; used by all modules by scoped names.
`default_nettype none

package lsi_pkg;

  localparam int CB  = 16;            // coordinate width
  localparam int DW  = CB + 1;        // coordinate difference width
  localparam int PW  = 2 * DW;        // cross product term width
  localparam int NW  = PW + 1;        // denominator / numerator width
  localparam int MW  = NW - 1;        // magnitude of denominator / numerator
  localparam int XW  = MW + DW;       // magnitude of numerator times delta
  localparam int QB  = 33;            // quotient bits kept before saturation
  localparam int DVW = XW + QB;       // padded dividend width
  localparam int SW  = QB + 2;        // start plus signed quotient
  localparam int OW  = 32;            // output point width

  typedef enum logic [1:0] {
    ST_INTERSECT  = 2'd0,
    ST_OUTSIDE    = 2'd1,
    ST_PARALLEL   = 2'd2,
    ST_COINCIDENT = 2'd3
  } status_t;

  typedef struct packed {
    logic                 vld;
    logic signed [DW-1:0] dxa;
    logic signed [DW-1:0] dya;
    logic signed [DW-1:0] dxb;
    logic signed [DW-1:0] dyb;
    logic signed [DW-1:0] ox;
    logic signed [DW-1:0] oy;
    logic signed [CB-1:0] ax0;
    logic signed [CB-1:0] ay0;
  } diff_t;

  typedef struct packed {
    logic                 vld;
    logic signed [PW-1:0] den1;
    logic signed [PW-1:0] den2;
    logic signed [PW-1:0] na1;
    logic signed [PW-1:0] na2;
    logic signed [PW-1:0] nb1;
    logic signed [PW-1:0] nb2;
    logic signed [DW-1:0] dxa;
    logic signed [DW-1:0] dya;
    logic signed [CB-1:0] ax0;
    logic signed [CB-1:0] ay0;
  } prod_t;

  typedef struct packed {
    logic                 vld;
    logic signed [NW-1:0] den;
    logic signed [NW-1:0] na;
    logic signed [NW-1:0] nb;
    logic signed [DW-1:0] dxa;
    logic signed [DW-1:0] dya;
    logic signed [CB-1:0] ax0;
    logic signed [CB-1:0] ay0;
  } front_t;

  // Fields that ride alongside the dividers.
  typedef struct packed {
    logic                 vld;
    status_t              status;
    logic                 dz;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] ax0;
    logic signed [CB-1:0] ay0;
  } side_t;

  typedef struct packed {
    logic          vld;
    logic          ovf;
    logic [MW-1:0] rem;
    logic [QB-1:0] lo;
    logic [MW-1:0] den;
    logic [QB-1:0] q;
  } div_t;

  typedef struct packed {
    logic                 sat;
    logic signed [OW-1:0] val;
  } point_t;

  function automatic logic [MW-1:0] mag_n(input logic signed [NW-1:0] v);
    logic signed [NW-1:0] t;
    t = v[NW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    t = v[DW-1] ? -v : v;
    return t;
  endfunction

  // True when n/d lies in [0,1], ends included; d nonzero.
  function automatic logic in_unit(input logic signed [NW-1:0] n,
                                   input logic signed [NW-1:0] d);
    logic r;
    if (!d[NW-1]) r = !n[NW-1] && (n <= d);
    else          r = (n <= 0) && (n >= d);
    return r;
  endfunction

  // Add the signed quotient to the start and clamp to the output range.
  function automatic point_t finish(input logic signed [CB-1:0] start,
                                    input logic [QB-1:0] q,
                                    input logic ovf, input logic neg);
    localparam logic signed [SW-1:0] OUT_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] OUT_MIN = SW'(-64'sd2147483648);
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] s;
    point_t p;
    qs = $signed({2'b00, q});
    s  = SW'(start) + (neg ? -qs : qs);
    if (ovf) begin
      p.sat = 1'b1;
      p.val = neg ? OUT_MIN[OW-1:0] : OUT_MAX[OW-1:0];
    end else if (s > OUT_MAX) begin
      p.sat = 1'b1;
      p.val = OUT_MAX[OW-1:0];
    end else if (s < OUT_MIN) begin
      p.sat = 1'b1;
      p.val = OUT_MIN[OW-1:0];
    end else begin
      p.sat = 1'b0;
      p.val = s[OW-1:0];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lsi_front.sv =====
// Front pipeline: coordinate differences, cross product terms, denominator and numerators.
// Depends on lsi_pkg.
`default_nettype none

module lsi_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic signed [lsi_pkg::CB-1:0] a_start_x,
  input  wire logic signed [lsi_pkg::CB-1:0] a_start_y,
  input  wire logic signed [lsi_pkg::CB-1:0] a_end_x,
  input  wire logic signed [lsi_pkg::CB-1:0] a_end_y,
  input  wire logic signed [lsi_pkg::CB-1:0] b_start_x,
  input  wire logic signed [lsi_pkg::CB-1:0] b_start_y,
  input  wire logic signed [lsi_pkg::CB-1:0] b_end_x,
  input  wire logic signed [lsi_pkg::CB-1:0] b_end_y,
  output lsi_pkg::front_t                  front
);

  lsi_pkg::diff_t  s1;
  lsi_pkg::prod_t  s2;
  lsi_pkg::front_t s3;

  // Stage 1: differences of the sign-extended coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else if (adv) begin
      s1.vld <= in_valid;
    end
    if (adv) begin
      s1.dxa <= lsi_pkg::DW'(a_end_x) - lsi_pkg::DW'(a_start_x);
      s1.dya <= lsi_pkg::DW'(a_end_y) - lsi_pkg::DW'(a_start_y);
      s1.dxb <= lsi_pkg::DW'(b_end_x) - lsi_pkg::DW'(b_start_x);
      s1.dyb <= lsi_pkg::DW'(b_end_y) - lsi_pkg::DW'(b_start_y);
      s1.ox  <= lsi_pkg::DW'(a_start_x) - lsi_pkg::DW'(b_start_x);
      s1.oy  <= lsi_pkg::DW'(a_start_y) - lsi_pkg::DW'(b_start_y);
      s1.ax0 <= a_start_x;
      s1.ay0 <= a_start_y;
    end
  end

  // Stage 2: six cross product terms
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld <= 1'b0;
    end else if (adv) begin
      s2.vld <= s1.vld;
    end
    if (adv) begin
      s2.den1 <= lsi_pkg::PW'($signed(s1.dyb)) * lsi_pkg::PW'($signed(s1.dxa));
      s2.den2 <= lsi_pkg::PW'($signed(s1.dxb)) * lsi_pkg::PW'($signed(s1.dya));
      s2.na1  <= lsi_pkg::PW'($signed(s1.dxb)) * lsi_pkg::PW'($signed(s1.oy));
      s2.na2  <= lsi_pkg::PW'($signed(s1.dyb)) * lsi_pkg::PW'($signed(s1.ox));
      s2.nb1  <= lsi_pkg::PW'($signed(s1.dxa)) * lsi_pkg::PW'($signed(s1.oy));
      s2.nb2  <= lsi_pkg::PW'($signed(s1.dya)) * lsi_pkg::PW'($signed(s1.ox));
      s2.dxa  <= s1.dxa;
      s2.dya  <= s1.dya;
      s2.ax0  <= s1.ax0;
      s2.ay0  <= s1.ay0;
    end
  end

  // Stage 3: denominator and both numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      s3.vld <= 1'b0;
    end else if (adv) begin
      s3.vld <= s2.vld;
    end
    if (adv) begin
      s3.den <= lsi_pkg::NW'($signed(s2.den1)) - lsi_pkg::NW'($signed(s2.den2));
      s3.na  <= lsi_pkg::NW'($signed(s2.na1)) - lsi_pkg::NW'($signed(s2.na2));
      s3.nb  <= lsi_pkg::NW'($signed(s2.nb1)) - lsi_pkg::NW'($signed(s2.nb2));
      s3.dxa <= s2.dxa;
      s3.dya <= s2.dya;
      s3.ax0 <= s2.ax0;
      s3.ay0 <= s2.ay0;
    end
  end

  assign front = s3;

endmodule

`default_nettype wire

// ===== hdl/lsi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Depends on lsi_pkg.
`default_nettype none

module lsi_divider (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    adv,
  input  wire logic                    in_vld,
  input  wire logic [lsi_pkg::XW-1:0]  dividend,
  input  wire logic [lsi_pkg::MW-1:0]  divisor,
  output logic                         out_vld,
  output logic                         out_ovf,
  output logic [lsi_pkg::QB-1:0]       quot
);

  lsi_pkg::div_t st [lsi_pkg::QB+1];

  logic [lsi_pkg::DVW-1:0] padded;
  logic [lsi_pkg::XW-1:0]  hi;

  assign padded = lsi_pkg::DVW'(dividend);
  assign hi     = padded[lsi_pkg::DVW-1:lsi_pkg::QB];

  // Entry stage: split dividend, flag a quotient too wide to keep
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].vld <= 1'b0;
    end else if (adv) begin
      st[0].vld <= in_vld;
    end
    if (adv) begin
      st[0].ovf <= (hi >= lsi_pkg::XW'(divisor));
      st[0].rem <= hi[lsi_pkg::MW-1:0];
      st[0].lo  <= padded[lsi_pkg::QB-1:0];
      st[0].den <= divisor;
      st[0].q   <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= lsi_pkg::QB; j++) begin : g_bit
    logic [lsi_pkg::MW:0] trial;
    logic [lsi_pkg::MW:0] diff;
    logic                 ge;

    assign trial = {st[j-1].rem, st[j-1].lo[lsi_pkg::QB-j]};
    assign ge    = trial >= {1'b0, st[j-1].den};
    assign diff  = trial - {1'b0, st[j-1].den};

    always_ff @(posedge clk) begin
      if (rst) begin
        st[j].vld <= 1'b0;
      end else if (adv) begin
        st[j].vld <= st[j-1].vld;
      end
      if (adv) begin
        st[j].ovf <= st[j-1].ovf;
        st[j].rem <= ge ? diff[lsi_pkg::MW-1:0] : trial[lsi_pkg::MW-1:0];
        st[j].lo  <= st[j-1].lo;
        st[j].den <= st[j-1].den;
        st[j].q   <= {st[j-1].q[lsi_pkg::QB-2:0], ge};
      end
    end
  end

  assign out_vld = st[lsi_pkg::QB].vld;
  assign out_ovf = st[lsi_pkg::QB].ovf;
  assign quot    = st[lsi_pkg::QB].q;

endmodule

`default_nettype wire

// ===== hdl/line_segment_intersection.sv =====
// Top level of the segment intersection pipeline: classification, point division, clamp.
// Depends on lsi_pkg, lsi_front, lsi_divider and line_segment_intersection_assert.svh.
`default_nettype none
`include "line_segment_intersection_assert.svh"

// Intersection of two 2D segments with exact integer arithmetic. One segment pair is
// accepted every cycle while the output is not stalled; each result passes through the
// 3 front stages (differences, cross products, sums), one classify stage, one
// magnitude product stage, the 34-stage restoring divider (an entry stage, then one
// quotient bit per stage) and the clamp/output register. A stall on the
// output freezes the whole pipe and is passed straight to in_stall. status is 0
// intersecting, 1 outside bounds, 2 parallel, 3 coincident; for 2 and 3 the point is
// zero. The point lies on the first segment's line, truncated toward zero, and
// saturates to the 32-bit signed range with point_saturated set.
module line_segment_intersection (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [lsi_pkg::CB-1:0] a_start_x,
  input  wire logic signed [lsi_pkg::CB-1:0] a_start_y,
  input  wire logic signed [lsi_pkg::CB-1:0] a_end_x,
  input  wire logic signed [lsi_pkg::CB-1:0] a_end_y,
  input  wire logic signed [lsi_pkg::CB-1:0] b_start_x,
  input  wire logic signed [lsi_pkg::CB-1:0] b_start_y,
  input  wire logic signed [lsi_pkg::CB-1:0] b_end_x,
  input  wire logic signed [lsi_pkg::CB-1:0] b_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic signed [lsi_pkg::OW-1:0]      cross_x,
  output logic signed [lsi_pkg::OW-1:0]      cross_y,
  output logic                               point_saturated
);

  logic            adv;
  lsi_pkg::front_t front;

  // Stage 4 registers
  lsi_pkg::side_t          s4;
  logic [lsi_pkg::MW-1:0]  s4_mna;
  logic [lsi_pkg::MW-1:0]  s4_mden;
  logic [lsi_pkg::DW-1:0]  s4_mdxa;
  logic [lsi_pkg::DW-1:0]  s4_mdya;

  // Stage 5 registers
  lsi_pkg::side_t          s5;
  logic [lsi_pkg::XW-1:0]  s5_px;
  logic [lsi_pkg::XW-1:0]  s5_py;
  logic [lsi_pkg::MW-1:0]  s5_mden;

  lsi_pkg::side_t side [lsi_pkg::QB+1];

  logic                    dvx_vld, dvx_ovf, dvy_vld, dvy_ovf;
  logic [lsi_pkg::QB-1:0]  dvx_q, dvy_q;
  lsi_pkg::point_t         px, py;
  lsi_pkg::side_t          tail;
  lsi_pkg::status_t        st4;

  // Advance the whole pipe unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  lsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .a_start_x (a_start_x),
    .a_start_y (a_start_y),
    .a_end_x   (a_end_x),
    .a_end_y   (a_end_y),
    .b_start_x (b_start_x),
    .b_start_y (b_start_y),
    .b_end_x   (b_end_x),
    .b_end_y   (b_end_y),
    .front     (front)
  );

  // Classify by sign comparisons of numerators against the denominator
  always_comb begin
    if (front.den == '0) begin
      st4 = (front.na == '0 && front.nb == '0) ? lsi_pkg::ST_COINCIDENT
                                               : lsi_pkg::ST_PARALLEL;
    end else if (lsi_pkg::in_unit(front.na, front.den) &&
                 lsi_pkg::in_unit(front.nb, front.den)) begin
      st4 = lsi_pkg::ST_INTERSECT;
    end else begin
      st4 = lsi_pkg::ST_OUTSIDE;
    end
  end

  // Stage 4: status, signs and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      s4.vld <= 1'b0;
    end else if (adv) begin
      s4.vld <= front.vld;
    end
    if (adv) begin
      s4.status <= st4;
      s4.dz     <= (front.den == '0);
      s4.negx   <= front.na[lsi_pkg::NW-1] ^ front.dxa[lsi_pkg::DW-1] ^
                   front.den[lsi_pkg::NW-1];
      s4.negy   <= front.na[lsi_pkg::NW-1] ^ front.dya[lsi_pkg::DW-1] ^
                   front.den[lsi_pkg::NW-1];
      s4.ax0    <= front.ax0;
      s4.ay0    <= front.ay0;
      s4_mna    <= lsi_pkg::mag_n(front.na);
      s4_mden   <= lsi_pkg::mag_n(front.den);
      s4_mdxa   <= lsi_pkg::mag_d(front.dxa);
      s4_mdya   <= lsi_pkg::mag_d(front.dya);
    end
  end

  // Stage 5: numerator magnitude times each delta magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      s5.vld <= 1'b0;
    end else if (adv) begin
      s5.vld <= s4.vld;
    end
    if (adv) begin
      s5.status <= s4.status;
      s5.dz     <= s4.dz;
      s5.negx   <= s4.negx;
      s5.negy   <= s4.negy;
      s5.ax0    <= s4.ax0;
      s5.ay0    <= s4.ay0;
      s5_px     <= lsi_pkg::XW'(s4_mna) * lsi_pkg::XW'(s4_mdxa);
      s5_py     <= lsi_pkg::XW'(s4_mna) * lsi_pkg::XW'(s4_mdya);
      s5_mden   <= s4_mden;
    end
  end

  lsi_divider u_div_x (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (s5.vld),
    .dividend (s5_px),
    .divisor  (s5_mden),
    .out_vld  (dvx_vld),
    .out_ovf  (dvx_ovf),
    .quot     (dvx_q)
  );

  lsi_divider u_div_y (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (s5.vld),
    .dividend (s5_py),
    .divisor  (s5_mden),
    .out_vld  (dvy_vld),
    .out_ovf  (dvy_ovf),
    .quot     (dvy_q)
  );

  // Carry status and starts alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= lsi_pkg::QB; i++) side[i].vld <= 1'b0;
    end else if (adv) begin
      side[0].vld <= s5.vld;
      for (int i = 1; i <= lsi_pkg::QB; i++) side[i].vld <= side[i-1].vld;
    end
    if (adv) begin
      side[0].status <= s5.status;
      side[0].dz     <= s5.dz;
      side[0].negx   <= s5.negx;
      side[0].negy   <= s5.negy;
      side[0].ax0    <= s5.ax0;
      side[0].ay0    <= s5.ay0;
      for (int i = 1; i <= lsi_pkg::QB; i++) begin
        side[i].status <= side[i-1].status;
        side[i].dz     <= side[i-1].dz;
        side[i].negx   <= side[i-1].negx;
        side[i].negy   <= side[i-1].negy;
        side[i].ax0    <= side[i-1].ax0;
        side[i].ay0    <= side[i-1].ay0;
      end
    end
  end

  assign tail = side[lsi_pkg::QB];
  assign px   = lsi_pkg::finish(tail.ax0, dvx_q, dvx_ovf, tail.negx);
  assign py   = lsi_pkg::finish(tail.ay0, dvy_q, dvy_ovf, tail.negy);

  // Output register: add start, clamp, zero the point for a zero denominator
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tail.vld;
    end
    if (adv) begin
      status <= tail.status;
      if (tail.dz) begin
        cross_x         <= '0;
        cross_y         <= '0;
        point_saturated <= 1'b0;
      end else begin
        cross_x         <= px.val;
        cross_y         <= py.val;
        point_saturated <= px.sat | py.sat;
      end
    end
  end

  `LSI_ASSERT_MSG(a_no_point_when_parallel,
    out_valid && (status == lsi_pkg::ST_PARALLEL || status == lsi_pkg::ST_COINCIDENT)
      |-> cross_x == '0 && cross_y == '0 && !point_saturated,
    "point not zero for a zero denominator")
  `LSI_ASSERT_MSG(a_divider_aligned,
    dvx_vld == tail.vld && dvy_vld == tail.vld,
    "divider valid out of step with side data")
  `LSI_ASSERT(a_sat_at_bound,
    out_valid && point_saturated |->
      cross_x == 32'sh7fffffff || cross_x == 32'sh80000000 ||
      cross_y == 32'sh7fffffff || cross_y == 32'sh80000000)

endmodule

`default_nettype wire

// ===== verif/line_segment_intersection_chk.sv =====
// Checker for line_segment_intersection: watches both channels, predicts each result
// from the accepted segment pair and compares it field by field. Depends on lsi_pkg.
module line_segment_intersection_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [lsi_pkg::CB-1:0] a_start_x,
  input  logic signed [lsi_pkg::CB-1:0] a_start_y,
  input  logic signed [lsi_pkg::CB-1:0] a_end_x,
  input  logic signed [lsi_pkg::CB-1:0] a_end_y,
  input  logic signed [lsi_pkg::CB-1:0] b_start_x,
  input  logic signed [lsi_pkg::CB-1:0] b_start_y,
  input  logic signed [lsi_pkg::CB-1:0] b_end_x,
  input  logic signed [lsi_pkg::CB-1:0] b_end_y,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    status,
  input  logic signed [31:0]            cross_x,
  input  logic signed [31:0]            cross_y,
  input  logic                          point_saturated,
  output int                            errors,
  output int                            pending,
  output int                            pairs_in,
  output int                            results_out,
  output int                            status_seen [4],
  output int                            sat_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    lsi_pkg::status_t   st;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sat;
  } crossing_t;

  crossing_t crossing_q[$];

  // One axis of the crossing point: start + trunc(num*delta/den), clamped to 32 bits.
  function automatic longint axis_point(input longint start, input longint num,
                                        input longint delta, input longint den,
                                        inout bit sat);
    longint unsigned q;
    longint          s;
    bit              neg;
    neg = ((num < 0) != (delta < 0)) != (den < 0);
    q = (unsigned'(num < 0 ? -num : num) *
         unsigned'(delta < 0 ? -delta : delta)) /
        unsigned'(den < 0 ? -den : den);
    if (q > 64'd1 << 40) begin
      sat = 1'b1;
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    s = neg ? start - longint'(q) : start + longint'(q);
    if (s > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (s < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return s;
  endfunction

  function automatic bit ratio_in_unit(input longint n, input longint d);
    if (d > 0) return n >= 0 && n <= d;
    return n <= 0 && n >= d;
  endfunction

  function automatic crossing_t predict_crossing();
    longint    dxa, dya, dxb, dyb, ox, oy, den, na, nb;
    bit        sat;
    crossing_t r;
    dxa = longint'(a_end_x) - longint'(a_start_x);
    dya = longint'(a_end_y) - longint'(a_start_y);
    dxb = longint'(b_end_x) - longint'(b_start_x);
    dyb = longint'(b_end_y) - longint'(b_start_y);
    ox  = longint'(a_start_x) - longint'(b_start_x);
    oy  = longint'(a_start_y) - longint'(b_start_y);
    den = dyb * dxa - dxb * dya;
    na  = dxb * oy - dyb * ox;
    nb  = dxa * oy - dya * ox;
    sat = 1'b0;
    r.px = '0;
    r.py = '0;
    if (den == 0) begin
      r.st = (na == 0 && nb == 0) ? lsi_pkg::ST_COINCIDENT : lsi_pkg::ST_PARALLEL;
    end else begin
      r.px = 32'(axis_point(longint'(a_start_x), na, dxa, den, sat));
      r.py = 32'(axis_point(longint'(a_start_y), na, dya, den, sat));
      r.st = (ratio_in_unit(na, den) && ratio_in_unit(nb, den)) ?
             lsi_pkg::ST_INTERSECT : lsi_pkg::ST_OUTSIDE;
    end
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_out, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    pairs_in = 0;
    results_out = 0;
    sat_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  end

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk) begin
    crossing_t e;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        crossing_q.push_back(predict_crossing());
        pairs_in++;
      end
      if (out_valid && !out_stall) begin
        if (crossing_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = crossing_q.pop_front();
          if (status !== e.st)
            report_mismatch($sformatf("status %0d, want %0d", status, e.st));
          if (cross_x !== e.px)
            report_mismatch($sformatf("cross_x %0d, want %0d", cross_x, e.px));
          if (cross_y !== e.py)
            report_mismatch($sformatf("cross_y %0d, want %0d", cross_y, e.py));
          if (point_saturated !== e.sat)
            report_mismatch($sformatf("saturated %0b, want %0b", point_saturated, e.sat));
          status_seen[e.st]++;
          if (e.sat) sat_seen++;
        end
        results_out++;
      end
    end
    pending = crossing_q.size();
  end

endmodule

// ===== verif/line_segment_intersection_tb.sv =====
// Testbench top for line_segment_intersection: clock, reset, segment pair stimulus,
// output stall pattern and verdict. Depends on lsi_pkg and line_segment_intersection_chk.
module line_segment_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PAIRS = 1800;
  localparam int IDLE_PCT     = 23;
  localparam int HOLD_CYCLES  = 150;
  localparam int STUCK_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 60;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [lsi_pkg::CB-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
  logic signed [lsi_pkg::CB-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
  logic [1:0] status;
  logic signed [lsi_pkg::OW-1:0] cross_x, cross_y;
  logic point_saturated;
  int errors, pending, pairs_in, results_out, sat_seen;
  int status_seen [4];
  bit idle_on, hold_req;

  line_segment_intersection i_dut (.*);

  line_segment_intersection_chk i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply reset once and keep every input at a known value.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {a_start_x, a_start_y, a_end_x, a_end_y} = '0;
    {b_start_x, b_start_y, b_end_x, b_end_y} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Drive one segment pair and hold it until the transfer happens.
  task automatic send_pair(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    a_start_x <= lsi_pkg::CB'(ax0); a_start_y <= lsi_pkg::CB'(ay0);
    a_end_x   <= lsi_pkg::CB'(ax1); a_end_y   <= lsi_pkg::CB'(ay1);
    b_start_x <= lsi_pkg::CB'(bx0); b_start_y <= lsi_pkg::CB'(by0);
    b_end_x   <= lsi_pkg::CB'(bx1); b_end_y   <= lsi_pkg::CB'(by1);
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int any_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(400)) - 200;
  endfunction

  // Pick one of several segment pair shapes with random content.
  task automatic send_random_pair();
    int ax0, ay0, dx, dy, bx0, by0, k0, k1, sx, sy;
    ax0 = near_coord(); ay0 = near_coord();
    dx  = near_coord(); dy  = near_coord();
    case ($urandom_range(9))
      0, 1: send_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord(), any_coord());
      2, 3, 4: send_pair(ax0, ay0, ax0 + dx, ay0 + dy,
                         near_coord(), near_coord(), near_coord(), near_coord());
      5: begin
        // parallel: B is A's direction scaled, from a random start
        k0 = $urandom_range(3) + 1;
        bx0 = near_coord(); by0 = near_coord();
        send_pair(ax0, ay0, ax0 + dx, ay0 + dy, bx0, by0, bx0 + k0 * dx, by0 + k0 * dy);
      end
      6: begin
        // collinear: B's ends lie on A's line
        k0 = int'($urandom_range(6)) - 3;
        k1 = int'($urandom_range(6)) - 3;
        send_pair(ax0, ay0, ax0 + dx, ay0 + dy,
                  ax0 + k0 * dx, ay0 + k0 * dy, ax0 + k1 * dx, ay0 + k1 * dy);
      end
      7: begin
        // degenerate A or B
        if ($urandom_range(1))
          send_pair(ax0, ay0, ax0, ay0, near_coord(), near_coord(), near_coord(), near_coord());
        else
          send_pair(ax0, ay0, ax0 + dx, ay0 + dy, ax0, ay0, ax0, ay0);
      end
      default: begin
        // nearly parallel long lines close together: can drive the point out of range
        sx = $urandom_range(1) ? 32767 : -32768;
        sy = $urandom_range(1) ? 32767 : -32768;
        send_pair(-sx - 1 + (sx < 0 ? 0 : 1), -sy, sx, sy,
                  -sx + ($urandom_range(1) ? 1 : -1), -sy + int'($urandom_range(4)) - 2,
                  sx - int'($urandom_range(3)), sy - int'($urandom_range(3)));
      end
    endcase
  endtask

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int held;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  initial begin
    int stuck;
    stuck = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("Timeout: no transfer in %0d cycles", STUCK_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    idle_on  = 1'b0;
    hold_req = 1'b0;
    @(negedge rst);
    @(posedge clk);

    // directed: extremes, each status, degenerate, saturation
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    send_pair(0, 0, 10, 0, 20, -5, 20, 5);
    send_pair(0, 0, 10, 0, 10, -5, 10, 5);
    send_pair(0, 0, 10, 0, 0, 0, 0, 5);
    send_pair(0, 0, 10, 10, 0, 5, 10, 15);
    send_pair(0, 0, 10, 10, 20, 20, 30, 30);
    send_pair(0, 0, 10, 10, 5, 5, 15, 15);
    send_pair(3, 3, 3, 3, 0, 0, 7, 9);
    send_pair(3, 3, 3, 3, 3, 3, 3, 3);
    send_pair(-32768, -32768, 32767, 32767, -32767, -32768, 32767, 32766);
    send_pair(32767, -32768, -32768, 32767, 32766, -32768, -32768, 32766);
    send_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 1);
    send_pair(-32768, -32768, -32768, -32768, 32767, 32767, -32768, 32767);
    send_pair(0, 0, 7, 3, 1, 5, 6, -2);
    send_pair(-1, -1, -1, 1, -2, 0, 0, 0);
    send_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);

    // random, first without idling, then with idling and one long hold-off
    for (n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == 300) idle_on = 1'b1;
      if (n == 900) hold_req = 1'b1;
      send_random_pair();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pairs, %0d results: intersect %0d outside %0d parallel %0d",
             pairs_in, results_out, status_seen[0], status_seen[1], status_seen[2]);
    $display("coincident %0d, saturated points %0d, %0d mismatches",
             status_seen[3], sat_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
